// ===== design/pbtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtp_pkg
// Shared constants and types of the palette bitplane tile packer.
// ----------------------------------------------------------------------------
package pbtp_pkg;

    localparam int TILE_SIZE       = 8;
    localparam int PALETTE_DEPTH   = 4;
    localparam int COLOR_W         = 32;
    localparam int INDEX_W         = 2;
    localparam int USED_W          = 3;
    localparam int WIDTH_W         = 7;
    localparam int COL_W           = 6;
    localparam int LINE_W          = 9;
    localparam int PIX_W           = 3;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_TILES = 7'd64;
    localparam logic [WIDTH_W-1:0] RESET_WIDTH_TILES = 7'd1;

    // Result of one palette lookup, as seen after this item is applied.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [USED_W-1:0]  used;
        logic               overflow;
    } t_pal_result;

endpackage

// ===== design/pbtp_palette.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtp_palette
// Four-entry color palette: parallel compare, append of unseen colors and
// overflow tracking. The lookup result is combinational from the stored state.
// ----------------------------------------------------------------------------
module pbtp_palette (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_clear,
    input  logic [pbtp_pkg::COLOR_W-1:0]  i_color,
    output pbtp_pkg::t_pal_result         o_res
);

    logic [pbtp_pkg::COLOR_W-1:0] r_pal [pbtp_pkg::PALETTE_DEPTH];
    logic [pbtp_pkg::USED_W-1:0]  r_cnt;
    logic                         r_ovf;

    logic [pbtp_pkg::USED_W-1:0]  cnt_eff;
    logic                         ovf_eff;
    logic [pbtp_pkg::PALETTE_DEPTH-1:0] hit;
    logic                         any_hit;
    logic [pbtp_pkg::INDEX_W-1:0] hit_idx;
    logic                         append;
    logic [pbtp_pkg::USED_W-1:0]  n_cnt;
    logic                         n_ovf;

    assign cnt_eff = i_clear ? '0 : r_cnt;
    assign ovf_eff = i_clear ? 1'b0 : r_ovf;

    always_comb begin
        for (int k = 0; k < pbtp_pkg::PALETTE_DEPTH; k++) begin
            hit[k] = (pbtp_pkg::USED_W'(k) < cnt_eff) && (r_pal[k] == i_color);
        end
    end

    // Entries are distinct, but the lowest match wins to keep the order explicit.
    always_comb begin
        hit_idx = '0;
        for (int k = pbtp_pkg::PALETTE_DEPTH - 1; k >= 0; k--) begin
            if (hit[k]) begin
                hit_idx = pbtp_pkg::INDEX_W'(k);
            end
        end
    end

    assign any_hit = |hit;
    assign append  = !any_hit && (cnt_eff < pbtp_pkg::USED_W'(pbtp_pkg::PALETTE_DEPTH));
    assign n_cnt   = append ? cnt_eff + 1'b1 : cnt_eff;
    assign n_ovf   = ovf_eff | (!any_hit && !append);

    always_comb begin
        o_res.used     = n_cnt;
        o_res.overflow = n_ovf;
        if (any_hit) begin
            o_res.index = hit_idx;
        end else if (append) begin
            o_res.index = cnt_eff[pbtp_pkg::INDEX_W-1:0];
        end else begin
            o_res.index = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_fire) begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    // Entries at or above the fill count are never compared, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_fire && append) begin
            r_pal[cnt_eff[pbtp_pkg::INDEX_W-1:0]] <= i_color;
        end
    end

endmodule

// ===== design/palette_bitplane_tile_packer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_bitplane_tile_packer_core
// Packs a raster stream of RGBA pixels into 2bpp bitplane tile lines.
// ----------------------------------------------------------------------------
// One pixel item is accepted per clock. Each pixel passes through an input
// register and is then coded against a four-entry palette by four parallel
// compares; every eighth pixel loads the result register with two bitplane
// bytes and the tile coordinates. The result register loads when the eighth
// pixel of a group leaves the input register, and the result is offered from
// the result register. The rate is one pixel per cycle, stalled only while a
// completed result waits in the output register and the next pixel would
// produce another. Set i_start_image on the first pixel of each image; the
// width register (in tiles) may be written only while the block is idle.
module palette_bitplane_tile_packer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_pixel_rgba,
    input  logic        i_start_image,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_tile_row,
    output logic [5:0]  o_grid_col,
    output logic [2:0]  o_line_in_tile,
    output logic [7:0]  o_plane_low,
    output logic [7:0]  o_plane_high,
    output logic [2:0]  o_palette_used,
    output logic        o_palette_overflow
);

    localparam int TW = pbtp_pkg::TILE_SIZE;

    logic [pbtp_pkg::WIDTH_W-1:0] r_width;

    logic                         r_s1_valid;
    logic [pbtp_pkg::COLOR_W-1:0] r_s1_rgba;
    logic                         r_s1_start;

    logic [pbtp_pkg::PIX_W-1:0]   r_pig;
    logic [TW-1:0]                r_low;
    logic [TW-1:0]                r_high;
    logic [pbtp_pkg::COL_W-1:0]   r_col;
    logic [pbtp_pkg::LINE_W-1:0]  r_line;

    logic                         r_out_valid;

    logic [pbtp_pkg::PIX_W-1:0]   pig_eff;
    logic [TW-1:0]                low_eff;
    logic [TW-1:0]                high_eff;
    logic [pbtp_pkg::COL_W-1:0]   col_eff;
    logic [pbtp_pkg::LINE_W-1:0]  line_eff;
    logic [TW-1:0]                n_low;
    logic [TW-1:0]                n_high;
    logic                         emit;
    logic                         out_free;
    logic                         s1_fire;
    logic                         in_fire;
    logic [pbtp_pkg::WIDTH_W-1:0] width_eff;
    logic [pbtp_pkg::WIDTH_W-1:0] next_col;
    pbtp_pkg::t_pal_result        pal_res;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= pbtp_pkg::RESET_WIDTH_TILES;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    // A start pixel sees the per-image state as cleared.
    assign pig_eff  = r_s1_start ? '0 : r_pig;
    assign low_eff  = r_s1_start ? '0 : r_low;
    assign high_eff = r_s1_start ? '0 : r_high;
    assign col_eff  = r_s1_start ? '0 : r_col;
    assign line_eff = r_s1_start ? '0 : r_line;

    assign emit     = (pig_eff == pbtp_pkg::PIX_W'(TW - 1));
    assign out_free = !r_out_valid || i_ready;
    assign s1_fire  = r_s1_valid && (out_free || !emit);
    assign o_ready  = !r_s1_valid || s1_fire;
    assign in_fire  = i_valid && o_ready;

    pbtp_palette u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_clear (r_s1_start),
        .i_color (r_s1_rgba),
        .o_res   (pal_res)
    );

    assign n_low  = {low_eff[TW-2:0], pal_res.index[0]};
    assign n_high = {high_eff[TW-2:0], pal_res.index[1]};

    always_comb begin
        if (r_width == '0) begin
            width_eff = pbtp_pkg::WIDTH_W'(1);
        end else if (r_width > pbtp_pkg::MAX_WIDTH_TILES) begin
            width_eff = pbtp_pkg::MAX_WIDTH_TILES;
        end else begin
            width_eff = r_width;
        end
    end

    assign next_col = {1'b0, col_eff} + 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_rgba  <= i_pixel_rgba;
            r_s1_start <= i_start_image;
        end
    end

    // Group shift bytes and raster position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pig  <= '0;
            r_low  <= '0;
            r_high <= '0;
            r_col  <= '0;
            r_line <= '0;
        end else if (s1_fire) begin
            if (emit) begin
                r_pig  <= '0;
                r_low  <= '0;
                r_high <= '0;
                if (next_col >= width_eff) begin
                    r_col  <= '0;
                    r_line <= line_eff + 1'b1;
                end else begin
                    r_col  <= next_col[pbtp_pkg::COL_W-1:0];
                    r_line <= line_eff;
                end
            end else begin
                r_pig  <= pig_eff + 1'b1;
                r_low  <= n_low;
                r_high <= n_high;
                r_col  <= col_eff;
                r_line <= line_eff;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emit) begin
            o_tile_row         <= line_eff[pbtp_pkg::LINE_W-1:3];
            o_grid_col         <= col_eff;
            o_line_in_tile     <= line_eff[2:0];
            o_plane_low        <= n_low;
            o_plane_high       <= n_high;
            o_palette_used     <= pal_res.used;
            o_palette_overflow <= pal_res.overflow;
        end
    end

    assign o_valid = r_out_valid;

    // A result is never overwritten while it waits for the consumer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(s1_fire && emit))
        else $error("result register overwritten while stalled");

    // The overflow flag only comes up once the palette is full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_palette_overflow) |-> (o_palette_used == 3'd4))
        else $error("overflow reported with palette not full");

    // A held pixel in the input register is not dropped.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> r_s1_valid)
        else $error("pending pixel lost from input register");

    // A completed group always resets the group shift counter.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && emit) |=> (r_pig == '0))
        else $error("pixel counter not cleared after a group");

endmodule
